@@ sv/bcd_date_validator_top_defines.svh @@
// ----------------------------------------------------------------------------
// bcd date validator assertion macros
// shared concurrent check helpers for the date validator rtl
// ----------------------------------------------------------------------------
`ifndef BCD_DATE_VALIDATOR_TOP_DEFINES_SVH
`define BCD_DATE_VALIDATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BDV_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bdv assertion failed");

// next-cycle implication
`define BDV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bdv assertion failed");

`endif

@@ sv/bdv_pkg.sv @@
// ----------------------------------------------------------------------------
// bdv_pkg
// types, constants and helpers for the packed-bcd date validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdv_pkg;

  localparam int unsigned LenW  = 3;
  localparam int unsigned ByteW = 8;

  localparam logic [LenW-1:0] LenShort = 3'd3;  // yy mm dd
  localparam logic [LenW-1:0] LenLong  = 3'd4;  // yyyy mm dd

  localparam logic [3:0] DigitLimit = 4'd10;
  localparam logic [3:0] MonthFeb   = 4'd2;
  localparam logic [3:0] MonthMax   = 4'd12;

  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
    logic [ByteW-1:0] b3;
  } date_word_t;

  // both nibbles below ten
  function automatic logic bcd_ok(input logic [ByteW-1:0] b);
    return (b[7:4] < DigitLimit) && (b[3:0] < DigitLimit);
  endfunction

  // binary value of a packed bcd byte, 0..165 for any pattern
  function automatic logic [7:0] bcd_val(input logic [ByteW-1:0] b);
    return 8'({b[7:4], 3'b000} + {2'b00, b[7:4], 1'b0} + {4'h0, b[3:0]});
  endfunction

  // days in month, february at its leap length
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd2:                      d = 5'd29;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ sv/bdv_check.sv @@
// ----------------------------------------------------------------------------
// bdv_check
// combinational validity check of one registered date word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdv_check (
  input  bdv_pkg::date_word_t word_i,
  output logic                ok_o
);

  logic                       len_ok;
  logic [bdv_pkg::ByteW-1:0]  yh, yl, mo, dy;
  logic [7:0]                 yh_v, yl_v, mo_v, dy_v;
  logic                       digits_ok;
  logic                       leap;
  logic                       month_ok;
  logic [4:0]                 max_day;

  always_comb begin
    len_ok = (word_i.len == bdv_pkg::LenShort) || (word_i.len == bdv_pkg::LenLong);
    if (word_i.len == bdv_pkg::LenLong) begin
      yh = word_i.b0;
      yl = word_i.b1;
      mo = word_i.b2;
      dy = word_i.b3;
    end else begin
      yh = '0;
      yl = word_i.b0;
      mo = word_i.b1;
      dy = word_i.b2;
    end
  end

  assign digits_ok = bdv_pkg::bcd_ok(yh) && bdv_pkg::bcd_ok(yl) &&
                     bdv_pkg::bcd_ok(mo) && bdv_pkg::bcd_ok(dy);

  assign yh_v = bdv_pkg::bcd_val(yh);
  assign yl_v = bdv_pkg::bcd_val(yl);
  assign mo_v = bdv_pkg::bcd_val(mo);
  assign dy_v = bdv_pkg::bcd_val(dy);

  // year = hi*100 + lo, and 100 is a multiple of 4: the century rule
  // reduces to the high part when the low part is zero
  assign leap = (yl_v == 8'd0) ? (yh_v[1:0] == 2'b00) : (yl_v[1:0] == 2'b00);

  assign month_ok = (mo_v != 8'd0) && (mo_v <= {4'h0, bdv_pkg::MonthMax});

  always_comb begin
    max_day = bdv_pkg::month_len(mo_v[3:0]);
    if ((mo_v[3:0] == bdv_pkg::MonthFeb) && !leap) begin
      max_day = 5'd28;
    end
  end

  assign ok_o = len_ok && digits_ok && month_ok &&
                (dy_v != 8'd0) && (dy_v <= {3'b000, max_day});

endmodule

`default_nettype wire

@@ sv/bcd_date_validator_top.sv @@
// ----------------------------------------------------------------------------
// bcd_date_validator_top
// packed-bcd calendar date validator, one date word per cycle
// ----------------------------------------------------------------------------
// usage:
//   a date word (length plus four bcd bytes) is taken at a rising edge where
//   start_i is high and busy_o is low. length 4 reads yyyy mm dd from bytes
//   0..3, length 3 reads yy mm dd from bytes 0..2 with the century as zero.
//   the verdict appears on date_ok_o, marked by done_o for one cycle, once the
//   word has passed through both register stages: one input register stage
//   and one result register stage, with the check logic between them.
//   throughput is one word per cycle; words follow each other back to back
//   and results come out in the same order.
//   busy_o is high during reset and for the first cycle after it, and low
//   from then on. reset clears the valid flags of both stages, so no result
//   is strobed for a word caught in flight.
//   the receiver cannot stall: every done_o pulse is the one and only chance
//   to take that result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bcd_date_validator_top_defines.svh"

module bcd_date_validator_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [bdv_pkg::LenW-1:0]  date_length_i,
  input  logic [bdv_pkg::ByteW-1:0] date_byte0_i,
  input  logic [bdv_pkg::ByteW-1:0] date_byte1_i,
  input  logic [bdv_pkg::ByteW-1:0] date_byte2_i,
  input  logic [bdv_pkg::ByteW-1:0] date_byte3_i,
  output logic                      done_o,
  output logic                      date_ok_o
);

  logic                busy_q;
  logic                in_valid_q, in_valid_d;
  bdv_pkg::date_word_t word_q, word_d;
  logic                done_q, done_d;
  logic                ok_q, ok_d;
  logic                accept;
  logic                check_ok;

  assign accept = start_i && !busy_q;

  assign in_valid_d = accept;
  assign word_d     = '{len: date_length_i, b0: date_byte0_i, b1: date_byte1_i,
                        b2: date_byte2_i, b3: date_byte3_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      busy_q     <= 1'b0;
      in_valid_q <= in_valid_d;
      done_q     <= done_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_d;
    end
    if (in_valid_q) begin
      ok_q <= ok_d;
    end
  end

  bdv_check u_check (
    .word_i (word_q),
    .ok_o   (check_ok)
  );

  assign done_d = in_valid_q;
  assign ok_d   = check_ok;

  assign busy_o    = busy_q;
  assign done_o    = done_q;
  assign date_ok_o = ok_q;

  // an accepted word reaches the check stage next cycle
  `BDV_ASSERT_NEXT(a_accept_to_check, clk_i, rst_ni, accept, in_valid_q)
  // every result strobe is preceded by a word in the check stage
  `BDV_ASSERT_IMPLIES(a_done_has_src, clk_i, rst_ni, done_o, $past(in_valid_q))
  // a passing verdict needs a legal length in the word that produced it
  `BDV_ASSERT_IMPLIES(a_ok_len, clk_i, rst_ni, done_o && date_ok_o,
    $past(word_q.len == bdv_pkg::LenShort) || $past(word_q.len == bdv_pkg::LenLong))

endmodule

`default_nettype wire
